// ----- rtl/core/arp_resolver_cache_core_defines.svh -----
// Assertion macros for the port-level checker of the ARP resolver core.
// No dependencies; every assertion is clocked and disabled during reset.
`ifndef ARP_RESOLVER_CACHE_CORE_DEFINES_SVH
`define ARP_RESOLVER_CACHE_CORE_DEFINES_SVH

// same-cycle implication
`define ARC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("arc check failed");

// next-cycle implication
`define ARC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("arc check failed");

`endif

// ----- rtl/core/arc_pkg.sv -----
// Package for the ARP resolver core: constants, codes, state and struct types.
// No dependencies.
`default_nettype none
package arc_pkg;
	localparam int CACHE_ENTRIES_D   = 16;
	localparam int PENDING_DEPTH_D   = 16;
	localparam int HOLDOFF_ENTRIES_D = 8;
	localparam int HANDLE_BITS_D     = 8;
	localparam int MAX_RESULTS       = 16;
	localparam int IN_TDATA_W        = 256;
	localparam int OUT_TDATA_W       = 96;

	localparam logic [31:0] TTL_RST     = 32'd30000;
	localparam logic [15:0] HOLDOFF_RST = 16'd5000;
	localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] MODE_SEND = 2'd0;
	localparam logic [1:0] MODE_RECV = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	localparam logic [1:0] KIND_IPV4 = 2'd0;
	localparam logic [1:0] KIND_ARP  = 2'd1;

	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	localparam logic [1:0] REG_LOCAL_IP  = 2'd0;
	localparam logic [1:0] REG_LOCAL_MAC = 2'd1;
	localparam logic [1:0] REG_TTL       = 2'd2;
	localparam logic [1:0] REG_HOLDOFF   = 2'd3;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_REQUEST = 3'd1,
		ACT_REPLY   = 3'd2,
		ACT_SEND    = 3'd3,
		ACT_DELIVER = 3'd4
	} act_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_CSCAN, ST_CDONE, ST_PSCAN, ST_PWRITE,
		ST_HSCAN, ST_HDONE, ST_RSCAN, ST_RDONE, ST_TCACHE, ST_THOLD
	} st_t;

	typedef enum logic [2:0] {
		EM_NONE, EM_DELIVER, EM_SEND_HIT, EM_REPLY, EM_REQUEST,
		EM_HELD_MID, EM_HELD_LAST
	} emit_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [47:0] local_mac;
		logic [31:0] ttl;
		logic [15:0] holdoff;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] next_hop_ip;
		logic [7:0]  datagram_id;
		logic [47:0] frame_dst_mac;
		logic [1:0]  frame_kind;
		logic        payload_ok;
		logic [15:0] arp_opcode;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] arp_tgt_ip;
		logic [31:0] elapsed_ms;
	} item_t;

	// sequencer -> datapath
	typedef struct packed {
		logic  ready;
		logic  cnt_clr;
		logic  cnt_inc;
		logic  scan_c;
		logic  scan_p;
		logic  scan_h;
		logic  scan_r;
		logic  age_c;
		logic  age_h;
		logic  learn_wr;
		logic  pend_wr;
		logic  hold_wr;
		logic  rel_init;
		logic  rel_take;
		emit_t emit;
	} ctrl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic [1:0] mode;
		logic rx_ipv4;
		logic rx_arp;
		logic req_local;
		logic is_reply;
		logic hit;
		logic hmatch;
		logic best;
		logic held;
		logic nfull;
		logic can_emit;
		logic last_c;
		logic last_p;
		logic last_h;
	} stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/arc_seq.sv -----
// Sequencer of the ARP resolver core: walks the scan and update phases.
// Depends on arc_pkg.
`default_nettype none
module arc_seq import arc_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	input  stat_t st,
	output ctrl_t ctrl
);
	st_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_n;
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
		ST_IDLE:   if (in_valid) state_n = ST_DECODE;
		ST_DECODE: begin
			case (st.mode)
			MODE_SEND: state_n = ST_CSCAN;
			MODE_RECV: begin
				if (st.rx_ipv4)     state_n = st.can_emit ? ST_IDLE : ST_DECODE;
				else if (st.rx_arp) state_n = ST_CSCAN;
				else                state_n = ST_IDLE;
			end
			MODE_TICK: state_n = ST_TCACHE;
			default:   state_n = ST_IDLE;
			endcase
		end
		ST_CSCAN:  if (st.last_c) state_n = ST_CDONE;
		ST_CDONE: begin
			if (st.mode == MODE_SEND) begin
				if (st.hit) state_n = st.can_emit ? ST_IDLE : ST_CDONE;
				else        state_n = ST_PSCAN;
			end else if (st.req_local) begin
				state_n = st.can_emit ? ST_IDLE : ST_CDONE;
			end else if (st.is_reply) begin
				state_n = ST_RSCAN;
			end else begin
				state_n = ST_IDLE;
			end
		end
		ST_PSCAN:  if (st.last_p) state_n = ST_PWRITE;
		ST_PWRITE: state_n = ST_HSCAN;
		ST_HSCAN:  if (st.last_h) state_n = ST_HDONE;
		ST_HDONE:  state_n = (st.hmatch || st.can_emit) ? ST_IDLE : ST_HDONE;
		ST_RSCAN:  if (st.last_p) state_n = ST_RDONE;
		ST_RDONE: begin
			if (st.best)
				state_n = (st.held && !st.nfull && !st.can_emit) ? ST_RDONE : ST_RSCAN;
			else
				state_n = (st.held && !st.can_emit) ? ST_RDONE : ST_IDLE;
		end
		ST_TCACHE: if (st.last_c) state_n = ST_THOLD;
		ST_THOLD:  if (st.last_h) state_n = ST_IDLE;
		default:   state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		ctrl.emit = EM_NONE;
		case (state_q)
		ST_IDLE:   ctrl.ready = 1'b1;
		ST_DECODE: begin
			ctrl.cnt_clr = 1'b1;
			if (st.mode == MODE_RECV && st.rx_ipv4 && st.can_emit) ctrl.emit = EM_DELIVER;
		end
		ST_CSCAN, ST_TCACHE: begin
			ctrl.scan_c  = (state_q == ST_CSCAN);
			ctrl.age_c   = (state_q == ST_TCACHE);
			ctrl.cnt_clr = st.last_c;
			ctrl.cnt_inc = !st.last_c;
		end
		ST_PSCAN, ST_RSCAN: begin
			ctrl.scan_p  = (state_q == ST_PSCAN);
			ctrl.scan_r  = (state_q == ST_RSCAN);
			ctrl.cnt_clr = st.last_p;
			ctrl.cnt_inc = !st.last_p;
		end
		ST_HSCAN, ST_THOLD: begin
			ctrl.scan_h  = (state_q == ST_HSCAN);
			ctrl.age_h   = (state_q == ST_THOLD);
			ctrl.cnt_clr = st.last_h;
			ctrl.cnt_inc = !st.last_h;
		end
		ST_CDONE: begin
			if (st.mode == MODE_SEND) begin
				if (st.hit && st.can_emit) ctrl.emit = EM_SEND_HIT;
			end else begin
				ctrl.learn_wr = 1'b1;
				if (st.req_local && st.can_emit) ctrl.emit = EM_REPLY;
				else if (!st.req_local && st.is_reply) ctrl.rel_init = 1'b1;
			end
		end
		ST_PWRITE: ctrl.pend_wr = 1'b1;
		ST_HDONE: begin
			if (!st.hmatch && st.can_emit) begin
				ctrl.hold_wr = 1'b1;
				ctrl.emit    = EM_REQUEST;
			end
		end
		ST_RDONE: begin
			if (st.best) begin
				if (!(st.held && !st.nfull && !st.can_emit)) begin
					ctrl.rel_take = 1'b1;
					if (st.held && !st.nfull) ctrl.emit = EM_HELD_MID;
				end
			end else if (st.held && st.can_emit) begin
				ctrl.emit = EM_HELD_LAST;
			end
		end
		default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/core/arc_dp.sv -----
// Datapath of the ARP resolver core: tables, shared scan/compare unit, output register.
// Depends on arc_pkg; driven by arc_seq.
`default_nettype none
module arc_dp import arc_pkg::*; #(
	parameter int CACHE_ENTRIES   = CACHE_ENTRIES_D,
	parameter int PENDING_DEPTH   = PENDING_DEPTH_D,
	parameter int HOLDOFF_ENTRIES = HOLDOFF_ENTRIES_D,
	parameter int HANDLE_BITS     = HANDLE_BITS_D
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  cfg_t                   cfg,
	input  ctrl_t                  ctrl,
	output stat_t                  st,
	input  wire                    in_valid,
	input  wire [IN_TDATA_W-1:0]   in_data,
	input  wire [1:0]              in_user,
	output logic                   out_valid,
	input  wire                    out_ready,
	output logic [OUT_TDATA_W-1:0] out_data,
	output logic                   out_last
);
	localparam int MAXN = (CACHE_ENTRIES > PENDING_DEPTH) ?
		((CACHE_ENTRIES > HOLDOFF_ENTRIES) ? CACHE_ENTRIES : HOLDOFF_ENTRIES) :
		((PENDING_DEPTH > HOLDOFF_ENTRIES) ? PENDING_DEPTH : HOLDOFF_ENTRIES);
	localparam int SW = $clog2(MAXN);
	localparam int CW = $clog2(CACHE_ENTRIES);
	localparam int PW = $clog2(PENDING_DEPTH);
	localparam int HW = (HOLDOFF_ENTRIES > 1) ? $clog2(HOLDOFF_ENTRIES) : 1;
	localparam int HB = HANDLE_BITS;

	// tables
	logic [CACHE_ENTRIES-1:0]   cvalid_q;
	logic [31:0]                cip_q   [CACHE_ENTRIES];
	logic [47:0]                cmac_q  [CACHE_ENTRIES];
	logic [31:0]                cage_q  [CACHE_ENTRIES];
	logic [PENDING_DEPTH-1:0]   pvalid_q;
	logic [31:0]                pip_q   [PENDING_DEPTH];
	logic [HB-1:0]              phandle_q [PENDING_DEPTH];
	logic [15:0]                pstamp_q [PENDING_DEPTH];
	logic [15:0]                arrival_q;
	logic [HOLDOFF_ENTRIES-1:0] hvalid_q;
	logic [31:0]                hip_q   [HOLDOFF_ENTRIES];
	logic [15:0]                hage_q  [HOLDOFF_ENTRIES];

	item_t       item_q;
	logic [SW-1:0] cnt_q;
	// shared scan registers
	logic          hit_q, free_q;
	logic [SW-1:0] hit_idx_q, free_idx_q, old_idx_q;
	logic [31:0]   old_age_q;
	logic [47:0]   hit_mac_q;
	logic [HB-1:0] hit_handle_q;
	// release bookkeeping
	logic          held_q;
	logic [HB-1:0] held_handle_q;
	logic [4:0]    n_q;

	logic [CW-1:0] ci;
	logic [PW-1:0] pi;
	logic [HW-1:0] hi;
	logic          first;
	logic [31:0]   key;
	logic          m;
	logic          fr;
	logic [31:0]   age_cur;
	logic [15:0]   rel_age;
	logic [32:0]   csum;
	logic [31:0]   cnew;
	logic [16:0]   hsum;
	logic [15:0]   hnew;
	logic [SW-1:0] wslot;
	logic [15:0]   id16;
	logic [HB-1:0] handle_in;
	logic [15:0]   hout16;
	act_t          act;
	logic [47:0]   o_mac;
	logic [31:0]   o_ip;
	logic [HB-1:0] o_handle;
	logic          o_last;
	logic          dst_ok;

	assign ci    = cnt_q[CW-1:0];
	assign pi    = cnt_q[PW-1:0];
	assign hi    = cnt_q[HW-1:0];
	assign first = (cnt_q == '0);
	assign key   = (item_q.mode == MODE_SEND) ? item_q.next_hop_ip : item_q.sender_ip;
	assign id16  = {8'd0, item_q.datagram_id};
	assign handle_in = id16[HB-1:0];

	// one compare unit, steered to the table under scan
	always_comb begin
		m       = 1'b0;
		fr      = 1'b0;
		age_cur = '0;
		rel_age = pstamp_q[pi];
		if (ctrl.scan_c) begin
			m       = cvalid_q[ci] && (cip_q[ci] == key);
			fr      = !cvalid_q[ci];
			age_cur = cage_q[ci];
		end else if (ctrl.scan_h) begin
			m       = hvalid_q[hi] && (hip_q[hi] == key);
			fr      = !hvalid_q[hi];
			age_cur = {16'd0, hage_q[hi]};
		end else if (ctrl.scan_p) begin
			fr = !pvalid_q[pi];
		end else if (ctrl.scan_r) begin
			m       = pvalid_q[pi] && (pip_q[pi] == key);
			rel_age = arrival_q - pstamp_q[pi];
			age_cur = {16'd0, rel_age};
		end
	end

	assign csum = {1'b0, cage_q[ci]} + {1'b0, item_q.elapsed_ms};
	assign cnew = csum[32] ? '1 : csum[31:0];
	assign hsum = {1'b0, hage_q[hi]} + {1'b0, item_q.elapsed_ms[15:0]};
	assign hnew = (hsum[16] || (item_q.elapsed_ms[31:16] != 16'd0)) ? '1 : hsum[15:0];
	assign wslot = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			cvalid_q  <= '0;
			pvalid_q  <= '0;
			hvalid_q  <= '0;
			arrival_q <= '0;
			held_q    <= 1'b0;
			n_q       <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
		end else begin
			if (ctrl.cnt_clr)      cnt_q <= '0;
			else if (ctrl.cnt_inc) cnt_q <= cnt_q + 1'b1;

			if (ctrl.scan_c || ctrl.scan_h || ctrl.scan_p || ctrl.scan_r) begin
				if (m && (first || !hit_q || (ctrl.scan_r && age_cur > old_age_q))) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cnt_q;
				end else if (first) begin
					hit_q <= 1'b0;
				end
				if (fr && (first || !free_q)) begin
					free_q     <= 1'b1;
					free_idx_q <= cnt_q;
				end else if (first) begin
					free_q <= 1'b0;
				end
			end

			if (ctrl.age_c && cvalid_q[ci] && cnew >= cfg.ttl) cvalid_q[ci] <= 1'b0;
			if (ctrl.age_h && hvalid_q[hi] && {16'd0, hnew} >= {16'd0, cfg.holdoff})
				hvalid_q[hi] <= 1'b0;

			if (ctrl.learn_wr) cvalid_q[wslot[CW-1:0]] <= 1'b1;
			if (ctrl.hold_wr)  hvalid_q[wslot[HW-1:0]] <= 1'b1;
			if (ctrl.pend_wr && free_q) begin
				pvalid_q[free_idx_q[PW-1:0]] <= 1'b1;
				arrival_q <= arrival_q + 16'd1;
			end

			if (ctrl.rel_init) begin
				held_q <= 1'b0;
				n_q    <= '0;
			end
			if (ctrl.rel_take) begin
				pvalid_q[hit_idx_q[PW-1:0]] <= 1'b0;
				if (!st.nfull) begin
					held_q <= 1'b1;
					n_q    <= n_q + 5'd1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && ctrl.ready)
			item_q <= {in_user, in_data[$bits(item_t)-3:0]};
		if (ctrl.scan_c || ctrl.scan_h || ctrl.scan_r) begin
			if (m && (first || !hit_q || (ctrl.scan_r && age_cur > old_age_q))) begin
				hit_mac_q    <= cmac_q[ci];
				hit_handle_q <= phandle_q[pi];
				if (ctrl.scan_r) old_age_q <= age_cur;
			end
			if (!ctrl.scan_r && (first || age_cur > old_age_q)) begin
				old_idx_q <= cnt_q;
				old_age_q <= age_cur;
			end
		end
		if (ctrl.age_c && cvalid_q[ci]) cage_q[ci] <= cnew;
		if (ctrl.age_h && hvalid_q[hi]) hage_q[hi] <= hnew;
		if (ctrl.learn_wr) begin
			cip_q[wslot[CW-1:0]]  <= item_q.sender_ip;
			cmac_q[wslot[CW-1:0]] <= item_q.sender_mac;
			cage_q[wslot[CW-1:0]] <= '0;
		end
		if (ctrl.hold_wr) begin
			hip_q[wslot[HW-1:0]]  <= item_q.next_hop_ip;
			hage_q[wslot[HW-1:0]] <= '0;
		end
		if (ctrl.pend_wr && free_q) begin
			pip_q[free_idx_q[PW-1:0]]     <= item_q.next_hop_ip;
			phandle_q[free_idx_q[PW-1:0]] <= handle_in;
			pstamp_q[free_idx_q[PW-1:0]]  <= arrival_q;
		end
		if (ctrl.rel_take && !st.nfull) held_handle_q <= hit_handle_q;
	end

	// result register
	always_comb begin
		act      = ACT_NONE;
		o_mac    = '0;
		o_ip     = '0;
		o_handle = '0;
		o_last   = 1'b1;
		case (ctrl.emit)
		EM_DELIVER:  act = ACT_DELIVER;
		EM_SEND_HIT: begin
			act      = ACT_SEND;
			o_mac    = hit_mac_q;
			o_ip     = item_q.next_hop_ip;
			o_handle = handle_in;
		end
		EM_REPLY: begin
			act   = ACT_REPLY;
			o_mac = item_q.sender_mac;
			o_ip  = item_q.sender_ip;
		end
		EM_REQUEST: begin
			act   = ACT_REQUEST;
			o_mac = MAC_BCAST;
			o_ip  = item_q.next_hop_ip;
		end
		EM_HELD_MID, EM_HELD_LAST: begin
			act      = ACT_SEND;
			o_mac    = item_q.sender_mac;
			o_ip     = item_q.sender_ip;
			o_handle = held_handle_q;
			o_last   = (ctrl.emit == EM_HELD_LAST);
		end
		default: ;
		endcase
	end

	assign hout16 = 16'(o_handle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                 out_valid <= 1'b0;
		else if (ctrl.emit != EM_NONE) out_valid <= 1'b1;
		else if (out_ready)          out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit != EM_NONE) begin
			out_data <= {5'd0, hout16[7:0], o_ip, o_mac, act};
			out_last <= o_last;
		end
	end

	assign dst_ok = (item_q.frame_dst_mac == MAC_BCAST) ||
		(item_q.frame_dst_mac == cfg.local_mac);

	always_comb begin
		st           = '0;
		st.mode      = item_q.mode;
		st.rx_ipv4   = dst_ok && item_q.frame_kind == KIND_IPV4 && item_q.payload_ok;
		st.rx_arp    = dst_ok && item_q.frame_kind == KIND_ARP && item_q.payload_ok;
		st.req_local = (item_q.arp_opcode == OP_REQUEST) && (item_q.arp_tgt_ip == cfg.local_ip);
		st.is_reply  = (item_q.arp_opcode == OP_REPLY);
		st.hit       = hit_q;
		st.hmatch    = hit_q;
		st.best      = hit_q;
		st.held      = held_q;
		st.nfull     = (n_q >= 5'(MAX_RESULTS));
		st.can_emit  = !out_valid || out_ready;
		st.last_c    = (cnt_q == SW'(CACHE_ENTRIES - 1));
		st.last_p    = (cnt_q == SW'(PENDING_DEPTH - 1));
		st.last_h    = (cnt_q == SW'(HOLDOFF_ENTRIES - 1));
	end
endmodule
`default_nettype wire

// ----- rtl/core/arp_resolver_cache_core.sv -----
// Top level of the ARP resolver core: configuration registers, sequencer, datapath.
// Depends on arc_pkg, arc_seq, arc_dp.
//
//  channel  | dir | handshake         | contents
//  s_*      | in  | s_tvalid/s_tready | one request: send, received frame or tick
//  m_*      | out | m_tvalid/m_tready | zero to sixteen results, tlast on the final one
//  cfg_*    | in  | cfg_we            | register write, no read-back
//
// One request at a time. The shared compare unit visits one table entry per cycle:
// a send scans the cache and, on a miss, the pending and hold-off tables; a tick
// ages the cache and hold-off tables; a reply releasing k handles scans the cache,
// then the pending table k+1 times.
// Reset clears all valid bits and the arrival counter, and loads the config
// registers with their reset values.
// A result waiting in the output register stalls the sequencer only when the
// next result is ready to be loaded.
`default_nettype none
module arp_resolver_cache_core import arc_pkg::*; #(
	parameter int CACHE_ENTRIES   = CACHE_ENTRIES_D,
	parameter int PENDING_DEPTH   = PENDING_DEPTH_D,
	parameter int HOLDOFF_ENTRIES = HOLDOFF_ENTRIES_D,
	parameter int HANDLE_BITS     = HANDLE_BITS_D
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	// from bit 0: next_hop_ip 32, datagram_id 8, frame_dst_mac 48, frame_kind 2,
	// payload_ok 1, arp_opcode 16, sender_ip 32, sender_mac 48, arp_tgt_ip 32,
	// elapsed_ms 32, zero fill
	input  wire [IN_TDATA_W-1:0]   s_tdata,
	input  wire [1:0]              s_tuser,   // mode
	output logic                   m_tvalid,
	input  wire                    m_tready,
	// from bit 0: action 3, dest_mac 48, about_ip 32, handle_out 8, zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  wire                    cfg_we,
	input  wire [1:0]              cfg_addr,
	input  wire [47:0]             cfg_wdata
);
	cfg_t  cfg_q;
	ctrl_t ctrl;
	stat_t st;
	logic [IN_TDATA_W-1:0] in_rev;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_ip  <= '0;
			cfg_q.local_mac <= '0;
			cfg_q.ttl       <= TTL_RST;
			cfg_q.holdoff   <= HOLDOFF_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
			REG_LOCAL_IP:  cfg_q.local_ip  <= cfg_wdata[31:0];
			REG_LOCAL_MAC: cfg_q.local_mac <= cfg_wdata;
			REG_TTL:       cfg_q.ttl       <= cfg_wdata[31:0];
			REG_HOLDOFF:   cfg_q.holdoff   <= cfg_wdata[15:0];
			default: ;
			endcase
		end
	end

	// reorder the wire packing (first field low) into the item struct layout
	always_comb begin
		in_rev = '0;
		in_rev[$bits(item_t)-3:0] = {
			s_tdata[31:0], s_tdata[39:32], s_tdata[87:40], s_tdata[89:88],
			s_tdata[90], s_tdata[106:91], s_tdata[138:107], s_tdata[186:139],
			s_tdata[218:187], s_tdata[250:219]};
	end

	assign s_tready = ctrl.ready;

	arc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.st       (st),
		.ctrl     (ctrl)
	);

	arc_dp #(
		.CACHE_ENTRIES   (CACHE_ENTRIES),
		.PENDING_DEPTH   (PENDING_DEPTH),
		.HOLDOFF_ENTRIES (HOLDOFF_ENTRIES),
		.HANDLE_BITS     (HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctrl      (ctrl),
		.st        (st),
		.in_valid  (s_tvalid),
		.in_data   (in_rev),
		.in_user   (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);
endmodule
`default_nettype wire

// ----- rtl/core/arc_checker.sv -----
// Port-level checker for the ARP resolver core, bound to the top level.
// Depends on arc_pkg and arp_resolver_cache_core_defines.svh.
`default_nettype none
`include "arp_resolver_cache_core_defines.svh"
module arc_checker import arc_pkg::*; (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   s_tvalid,
	input wire                   s_tready,
	input wire                   m_tvalid,
	input wire                   m_tready,
	input wire [OUT_TDATA_W-1:0] m_tdata,
	input wire                   m_tlast
);
	// result held until taken
	`ARC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	// busy right after taking a request
	`ARC_ASSERT_NEXT(a_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// no result carries the none action
	`ARC_ASSERT_NOW(a_act, clk, arst_n, m_tvalid, m_tdata[2:0] == ACT_REQUEST || m_tdata[2:0] == ACT_REPLY || m_tdata[2:0] == ACT_SEND || m_tdata[2:0] == ACT_DELIVER)
	// a request is a lone broadcast without a handle
	`ARC_ASSERT_NOW(a_req, clk, arst_n, m_tvalid && m_tdata[2:0] == ACT_REQUEST, m_tlast && m_tdata[50:3] == MAC_BCAST && m_tdata[90:83] == 8'd0)
endmodule

bind arp_resolver_cache_core arc_checker u_arc_checker (.*);
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for arp_resolver_cache_core: stream requests in, compare results.
// Depends on arc_pkg and the core RTL; carries its own cache/pending/hold-off predictor.
`timescale 1ns / 1ps
module tb_top;
	import arc_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE      = 400;	// worst reply scan plus margin
	localparam int NIP         = 24;	// pool of next-hop addresses

	typedef struct {
		act_t        act;
		logic [47:0] mac;
		logic [31:0] ip;
		logic [7:0]  handle;
		logic        last;
	} result_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0, cfg_we = 0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0, cfg_addr = '0;
	logic [47:0] cfg_wdata = '0;
	wire s_tready, m_tvalid, m_tlast;
	wire [OUT_TDATA_W-1:0] m_tdata;

	arp_resolver_cache_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial forever #5 clk = ~clk;

	// predictor copy of configuration and tables
	logic [31:0] my_ip, ttl;
	logic [47:0] my_mac;
	logic [15:0] holdoff;
	logic        c_val [CACHE_ENTRIES_D];
	logic [31:0] c_ip  [CACHE_ENTRIES_D];
	logic [47:0] c_mac [CACHE_ENTRIES_D];
	logic [31:0] c_age [CACHE_ENTRIES_D];
	logic        p_val [PENDING_DEPTH_D];
	logic [31:0] p_ip  [PENDING_DEPTH_D];
	logic [7:0]  p_hdl [PENDING_DEPTH_D];
	logic [15:0] p_stamp [PENDING_DEPTH_D];
	logic [15:0] arrivals;
	logic        h_val [HOLDOFF_ENTRIES_D];
	logic [31:0] h_ip  [HOLDOFF_ENTRIES_D];
	logic [15:0] h_age [HOLDOFF_ENTRIES_D];

	item_t   req_queue[$];
	result_t exp_results[$];
	int      errors = 0;
	logic    quiet = 0;          // no idling in the final part
	logic    long_stall_due = 0; // ask the sink for one long hold
	logic [31:0] ip_pool [NIP];

	task automatic report(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		errors++;
	endtask

	task automatic add_result(input act_t a, input logic [47:0] mac, input logic [31:0] ip,
			input logic [7:0] h);
		result_t r;
		r.act = a; r.mac = mac; r.ip = ip; r.handle = h; r.last = 1'b0;
		exp_results.push_back(r);
	endtask

	task automatic learn_mapping(input logic [31:0] ip, input logic [47:0] mac);
		int slot;
		slot = -1;
		for (int i = 0; i < CACHE_ENTRIES_D; i++)
			if (slot < 0 && c_val[i] && c_ip[i] == ip) slot = i;
		for (int i = 0; i < CACHE_ENTRIES_D; i++)
			if (slot < 0 && !c_val[i]) slot = i;
		if (slot < 0) begin
			// table full: evict the oldest, lowest index on a tie
			slot = 0;
			for (int i = 1; i < CACHE_ENTRIES_D; i++)
				if (c_age[i] > c_age[slot]) slot = i;
		end
		c_val[slot] = 1; c_ip[slot] = ip; c_mac[slot] = mac; c_age[slot] = '0;
	endtask

	// works out the results of one accepted request and updates the tables
	task automatic resolve_request(input item_t it);
		int slot, n0;
		logic [15:0] a, best_age;
		n0 = exp_results.size();
		if (it.mode == MODE_SEND) begin
			slot = -1;
			for (int i = 0; i < CACHE_ENTRIES_D; i++)
				if (slot < 0 && c_val[i] && c_ip[i] == it.next_hop_ip) slot = i;
			if (slot >= 0) add_result(ACT_SEND, c_mac[slot], it.next_hop_ip, it.datagram_id);
			else begin
				for (int i = 0; i < PENDING_DEPTH_D; i++)
					if (slot < 0 && !p_val[i]) slot = i;
				if (slot >= 0) begin	// full queue drops the handle
					p_val[slot] = 1; p_ip[slot] = it.next_hop_ip;
					p_hdl[slot] = it.datagram_id; p_stamp[slot] = arrivals;
					arrivals++;
				end
				slot = -1;
				for (int i = 0; i < HOLDOFF_ENTRIES_D; i++)
					if (h_val[i] && h_ip[i] == it.next_hop_ip) slot = -2;
				if (slot == -1) begin
					for (int i = 0; i < HOLDOFF_ENTRIES_D; i++)
						if (slot < 0 && !h_val[i]) slot = i;
					if (slot < 0) begin
						slot = 0;
						for (int i = 1; i < HOLDOFF_ENTRIES_D; i++)
							if (h_age[i] > h_age[slot]) slot = i;
					end
					h_val[slot] = 1; h_ip[slot] = it.next_hop_ip; h_age[slot] = '0;
					add_result(ACT_REQUEST, MAC_BCAST, it.next_hop_ip, '0);
				end
			end
		end else if (it.mode == MODE_RECV) begin
			if (it.frame_dst_mac == MAC_BCAST || it.frame_dst_mac == my_mac) begin
				if (it.frame_kind == KIND_IPV4 && it.payload_ok)
					add_result(ACT_DELIVER, '0, '0, '0);
				else if (it.frame_kind == KIND_ARP && it.payload_ok) begin
					learn_mapping(it.sender_ip, it.sender_mac);
					if (it.arp_opcode == OP_REQUEST && it.arp_tgt_ip == my_ip)
						add_result(ACT_REPLY, it.sender_mac, it.sender_ip, '0);
					else if (it.arp_opcode == OP_REPLY)
						forever begin
							// release oldest first by wrapped arrival distance
							slot = -1; best_age = '0;
							for (int i = 0; i < PENDING_DEPTH_D; i++)
								if (p_val[i] && p_ip[i] == it.sender_ip) begin
									a = arrivals - p_stamp[i];
									if (slot < 0 || a > best_age) begin
										slot = i; best_age = a;
									end
								end
							if (slot < 0) break;
							p_val[slot] = 0;
							if (exp_results.size() - n0 < MAX_RESULTS)
								add_result(ACT_SEND, it.sender_mac, it.sender_ip, p_hdl[slot]);
						end
				end
			end
		end else if (it.mode == MODE_TICK) begin
			for (int i = 0; i < CACHE_ENTRIES_D; i++)
				if (c_val[i]) begin
					logic [32:0] s;
					s = c_age[i] + it.elapsed_ms;
					c_age[i] = s[32] ? 32'hFFFF_FFFF : s[31:0];
					if (c_age[i] >= ttl) c_val[i] = 0;
				end
			for (int i = 0; i < HOLDOFF_ENTRIES_D; i++)
				if (h_val[i]) begin
					logic [32:0] s;
					s = h_age[i] + it.elapsed_ms;
					h_age[i] = (s > 33'hFFFF) ? 16'hFFFF : s[15:0];
					if (h_age[i] >= holdoff) h_val[i] = 0;
				end
		end
		if (exp_results.size() > n0) exp_results[$].last = 1'b1;
	endtask

	function automatic logic [IN_TDATA_W-1:0] pack_item(input item_t it);
		return {5'd0, it.elapsed_ms, it.arp_tgt_ip, it.sender_mac, it.sender_ip,
			it.arp_opcode, it.payload_ok, it.frame_kind, it.frame_dst_mac,
			it.datagram_id, it.next_hop_ip};
	endfunction

	// driver: pops pending requests, predicts each at its acceptance edge
	item_t cur;
	int    src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				resolve_request(cur);
				if (!quiet && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 11);
			end
			if (src_gap > 0) begin
				src_gap--;
				s_tvalid <= 1'b0;
			end else if (req_queue.size() > 0) begin
				cur = req_queue.pop_front();
				s_tdata <= pack_item(cur);
				s_tuser <= cur.mode;
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// sink: random stall bursts plus one long hold that backs the core up
	int sink_hold = 0;
	logic long_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (long_stall_due && !long_done) begin
				long_done <= 1'b1;
				sink_hold = 600;
			end else if (sink_hold == 0 && !quiet && $urandom_range(0, 6) == 0)
				sink_hold = $urandom_range(1, 11);
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_results.size() == 0)
				report($sformatf("unexpected result %h", m_tdata));
			else begin
				result_t e;
				e = exp_results.pop_front();
				if (m_tdata[2:0] != e.act)
					report($sformatf("action %0d want %0d", m_tdata[2:0], e.act));
				if (m_tdata[50:3] != e.mac)
					report($sformatf("dest_mac %h want %h", m_tdata[50:3], e.mac));
				if (m_tdata[82:51] != e.ip)
					report($sformatf("about_ip %h want %h", m_tdata[82:51], e.ip));
				if (m_tdata[90:83] != e.handle)
					report($sformatf("handle %h want %h", m_tdata[90:83], e.handle));
				if (m_tdata[OUT_TDATA_W-1:91] != '0) report("nonzero fill bits");
				if (m_tlast != e.last)
					report($sformatf("tlast %0b want %0b", m_tlast, e.last));
			end
		end
	end

	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LOCAL_IP:  my_ip = val[31:0];
			REG_LOCAL_MAC: my_mac = val;
			REG_TTL:       ttl = val[31:0];
			REG_HOLDOFF:   holdoff = val[15:0];
			default: ;
		endcase
	endtask

	// all requests accepted, all results seen, then let silent work finish
	task automatic drain();
		wait (req_queue.size() == 0 && !s_tvalid && exp_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [47:0] rnd48();
		return {$urandom(), $urandom()};
	endfunction

	function automatic item_t blank(input logic [1:0] mode);
		item_t it;
		it = '0;
		it.mode = mode;
		return it;
	endfunction

	function automatic item_t send_to(input logic [31:0] ip);
		item_t it;
		it = blank(MODE_SEND);
		it.next_hop_ip = ip;
		it.datagram_id = 8'($urandom());
		return it;
	endfunction

	function automatic item_t arp_frame(input logic [15:0] op, input logic [31:0] sip,
			input logic [31:0] tip);
		item_t it;
		it = blank(MODE_RECV);
		it.frame_dst_mac = $urandom_range(0, 1) ? MAC_BCAST : my_mac;
		it.frame_kind = KIND_ARP;
		it.payload_ok = 1'b1;
		it.arp_opcode = op;
		it.sender_ip = sip;
		it.sender_mac = rnd48();
		it.arp_tgt_ip = tip;
		return it;
	endfunction

	function automatic item_t tick(input logic [31:0] ms);
		item_t it;
		it = blank(MODE_TICK);
		it.elapsed_ms = ms;
		return it;
	endfunction

	// mostly resolve flows on a small address pool, some noise
	function automatic item_t random_item();
		item_t it;
		int pick;
		logic [31:0] ip;
		pick = $urandom_range(0, 99);
		ip = ip_pool[$urandom_range(0, NIP - 1)];
		if (pick < 38) it = send_to(ip);
		else if (pick < 58) it = arp_frame(OP_REPLY, ip, $urandom());
		else if (pick < 66) it = arp_frame(OP_REQUEST, ip, $urandom_range(0, 1) ? my_ip : ip);
		else if (pick < 74) begin
			it = blank(MODE_RECV);
			it.frame_dst_mac = $urandom_range(0, 1) ? my_mac : MAC_BCAST;
			it.payload_ok = $urandom_range(0, 3) != 0;
		end else if (pick < 84) begin
			// noise: every input field random
			it = blank($urandom_range(0, 1) ? MODE_RECV : MODE_SEND);
			it.next_hop_ip = $urandom(); it.datagram_id = 8'($urandom());
			it.frame_dst_mac = $urandom_range(0, 2) == 0 ? my_mac : rnd48();
			it.frame_kind = 2'($urandom_range(0, 2)); it.payload_ok = 1'($urandom());
			it.arp_opcode = 16'($urandom()); it.sender_ip = $urandom();
			it.sender_mac = rnd48(); it.arp_tgt_ip = $urandom();
			it.elapsed_ms = $urandom();
		end else
			it = tick($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 4000));
		return it;
	endfunction

	task automatic random_phase(input int count);
		for (int k = 0; k < count; k++) req_queue.push_back(random_item());
	endtask

	initial begin
		item_t it;
		my_ip = '0; my_mac = '0; ttl = TTL_RST; holdoff = HOLDOFF_RST; arrivals = '0;
		foreach (c_val[i]) begin c_val[i] = 0; c_age[i] = '0; c_ip[i] = '0; c_mac[i] = '0; end
		foreach (p_val[i]) begin p_val[i] = 0; p_ip[i] = '0; p_hdl[i] = '0; p_stamp[i] = '0; end
		foreach (h_val[i]) begin h_val[i] = 0; h_age[i] = '0; h_ip[i] = '0; end
		foreach (ip_pool[i]) ip_pool[i] = $urandom();
		ip_pool[0] = '0; ip_pool[1] = '1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part on reset ttl/hold-off
		write_reg(REG_LOCAL_IP, 48'hC0A8_0001);
		write_reg(REG_LOCAL_MAC, 48'h0200_0000_0001);
		req_queue.push_back(arp_frame(OP_REQUEST, ip_pool[2], my_ip));	// reply to us
		it = blank(MODE_RECV); it.frame_dst_mac = my_mac; it.payload_ok = 1;
		req_queue.push_back(it);					// IPv4 delivered
		it.frame_dst_mac = 48'h0200_0000_0002; req_queue.push_back(it);	// not for us
		it.frame_dst_mac = MAC_BCAST; it.payload_ok = 0; req_queue.push_back(it);
		it.frame_kind = 2'd2; it.payload_ok = 1; req_queue.push_back(it);	// other kind
		it = arp_frame(16'hFFFF, ip_pool[3], my_ip); req_queue.push_back(it);	// odd opcode
		req_queue.push_back(send_to(ip_pool[3]));			// hit
		// pending overflow: seventeen sends to one address, then the reply
		for (int k = 0; k < 17; k++) req_queue.push_back(send_to(ip_pool[0]));
		req_queue.push_back(arp_frame(OP_REPLY, ip_pool[0], '1));
		// hold-off table overflow
		for (int k = 0; k < 10; k++) req_queue.push_back(send_to(32'h0A00_0000 + k));
		// cache overflow, then saturating tick that expires everything
		for (int k = 0; k < 18; k++)
			req_queue.push_back(arp_frame(OP_REQUEST, 32'h0B00_0000 + k, '0));
		req_queue.push_back(tick(32'hFFFF_FFFF));
		req_queue.push_back(tick(32'hFFFF_FFFF));
		drain();

		// shortest lifetimes
		write_reg(REG_TTL, 48'd1);
		write_reg(REG_HOLDOFF, 48'd1);
		random_phase(90);
		drain();

		// longest lifetimes; long sink hold while requests keep coming
		write_reg(REG_TTL, 48'hFFFF_FFFF);
		write_reg(REG_HOLDOFF, 48'hFFFF);
		write_reg(REG_LOCAL_MAC, 48'hFFFF_FFFF_FFFF);
		long_stall_due <= 1'b1;
		random_phase(70);
		drain();
		random_phase(70);
		drain();

		// ordinary values, address zero, mac zero
		write_reg(REG_LOCAL_IP, 48'd0);
		write_reg(REG_LOCAL_MAC, 48'd0);
		write_reg(REG_TTL, 48'd9000);
		write_reg(REG_HOLDOFF, 48'd2500);
		random_phase(65);
		drain();

		write_reg(REG_LOCAL_IP, 48'hFFFF_FFFF);
		write_reg(REG_LOCAL_MAC, 48'h0A1B_2C3D_4E5F);
		random_phase(70);
		drain();
		quiet <= 1'b1;
		random_phase(50);
		drain();

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
